FILE: design/mosa_pkg.sv
// Package for the median-of-two-sorted-arrays core.
// Holds the sizes, data types and store access structs used across the design and the testbench.
`default_nettype none
package mosa_pkg;
	localparam int DEPTH      = 1024;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = ADDR_W + 1;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic [ADDR_W-1:0]            addr_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	// One write into both stores at the same address.
	typedef struct packed {
		logic  en;
		addr_t addr;
		data_t first_value;
		data_t second_value;
	} store_wr_t;

	// Read addresses for the two stores.
	typedef struct packed {
		addr_t first_addr;
		addr_t second_addr;
	} store_rd_t;
endpackage
`default_nettype wire

FILE: design/mosa_if.sv
// Handshake interfaces of the median core: the pair input and the result output.
// Depends on mosa_pkg for the data type.
`default_nettype none
interface mosa_pair_if;
	import mosa_pkg::*;
	logic  valid;
	logic  ready;
	data_t first_value;
	data_t second_value;
	logic  last_pair;
	modport source(output valid, output first_value, output second_value,
		output last_pair, input ready);
	modport sink(input valid, input first_value, input second_value,
		input last_pair, output ready);
endinterface

interface mosa_result_if;
	import mosa_pkg::*;
	logic  valid;
	logic  ready;
	data_t median_value;
	modport source(output valid, output median_value, input ready);
	modport sink(input valid, input median_value, output ready);
endinterface
`default_nettype wire

FILE: design/median_of_two_sorted_arrays_core.sv
// Top level of the median core: load sequencer, halving search and result register.
// Depends on mosa_pkg, mosa_if and mosa_store.
`default_nettype none
// Pairs of elements from two ascending signed sequences are taken one per cycle while
// the core is idle and written side by side into two 1024-entry stores; pairs beyond
// 1024 are dropped. The transaction with last_pair set starts the search, and the
// input stays not ready until the median has been placed in the result register.
// Each halving step is a store read in S_CHECK, then the shared compare in S_CMP.
// For a set of N pairs the result is the lower median of all 2N values; a new set
// may load while the previous result waits to be taken.
module median_of_two_sorted_arrays_core (
	input wire logic     clk,
	input wire logic     arst_n,
	mosa_pair_if.sink    pairs,
	mosa_result_if.source result
);
	import mosa_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_LAST  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	cnt_t       pair_count_q;
	addr_t      first_low_q, first_high_q, second_low_q, second_high_q;
	data_t      answer_q;
	logic       result_valid_q;
	data_t      result_data_q;

	store_wr_t wr;
	store_rd_t rd;
	data_t     first_data, second_data;

	logic          accept;
	logic          room;
	logic [CNT_W-1:0] first_span, second_span;
	addr_t         first_mid, second_mid;
	logic          odd_len;
	logic          searching;
	logic          vals_equal, second_less;
	data_t         smaller;
	addr_t         init_high;

	assign accept = pairs.valid && pairs.ready;
	assign room   = pair_count_q < cnt_t'(DEPTH);

	assign pairs.ready         = (state_q == S_IDLE);
	assign result.valid        = result_valid_q;
	assign result.median_value = result_data_q;

	always_comb begin
		wr.en           = accept && room;
		wr.addr         = pair_count_q[ADDR_W-1:0];
		wr.first_value  = pairs.first_value;
		wr.second_value = pairs.second_value;
	end

	assign first_span  = {1'b0, first_low_q} + {1'b0, first_high_q};
	assign second_span = {1'b0, second_low_q} + {1'b0, second_high_q};
	assign first_mid   = first_span[CNT_W-1:1];
	assign second_mid  = second_span[CNT_W-1:1];
	// An even sum of the bounds means the live range has an odd length.
	assign odd_len     = !first_span[0];
	assign searching   = (first_low_q != first_high_q) && (second_low_q != second_high_q);

	always_comb begin
		if (searching) begin
			rd.first_addr  = first_mid;
			rd.second_addr = second_mid;
		end else begin
			rd.first_addr  = first_low_q;
			rd.second_addr = second_low_q;
		end
	end

	// The one comparator, shared by every halving step and the final pick.
	assign vals_equal  = (first_data == second_data);
	assign second_less = (second_data < first_data);
	assign smaller     = second_less ? second_data : first_data;

	// The last pair's index, which equals the old count unless the set overflowed.
	assign init_high = room ? pair_count_q[ADDR_W-1:0] : addr_t'(DEPTH - 1);

	mosa_store u_store (
		.clk         (clk),
		.wr          (wr),
		.rd          (rd),
		.first_data  (first_data),
		.second_data (second_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pair_count_q  <= '0;
			first_low_q   <= '0;
			first_high_q  <= '0;
			second_low_q  <= '0;
			second_high_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (pairs.last_pair) begin
							pair_count_q  <= '0;
							first_low_q   <= '0;
							first_high_q  <= init_high;
							second_low_q  <= '0;
							second_high_q <= init_high;
							state_q       <= S_CHECK;
						end else if (room) begin
							pair_count_q <= pair_count_q + cnt_t'(1);
						end
					end
				end
				S_CHECK: begin
					state_q <= searching ? S_CMP : S_LAST;
				end
				S_CMP: begin
					if (vals_equal) begin
						state_q <= S_DONE;
					end else if (second_less) begin
						first_high_q <= first_mid;
						second_low_q <= odd_len ? second_mid : second_mid + addr_t'(1);
						state_q      <= S_CHECK;
					end else begin
						second_high_q <= second_mid;
						first_low_q   <= odd_len ? first_mid : first_mid + addr_t'(1);
						state_q       <= S_CHECK;
					end
				end
				S_LAST: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!result_valid_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Answer holding register; on an equal midpoint either value serves.
	always_ff @(posedge clk) begin
		if (state_q == S_CMP && vals_equal) begin
			answer_q <= first_data;
		end else if (state_q == S_LAST) begin
			answer_q <= smaller;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!result_valid_q || result.ready)) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!result_valid_q || result.ready)) begin
			result_data_q <= answer_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> first_low_q <= first_high_q && second_low_q <= second_high_q)
		else $error("search bounds crossed");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> $past(state_q) == S_CHECK)
		else $error("compare without a store read");

	assert property (@(posedge clk) disable iff (!arst_n)
		pair_count_q <= cnt_t'(DEPTH))
		else $error("pair count beyond store depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside the done state");
endmodule
`default_nettype wire

FILE: design/mosa_store.sv
// The two element stores of the median core, one write port and registered reads.
// Depends on mosa_pkg for sizes and the access structs.
`default_nettype none
module mosa_store (
	input  wire logic              clk,
	input  wire mosa_pkg::store_wr_t wr,
	input  wire mosa_pkg::store_rd_t rd,
	output mosa_pkg::data_t        first_data,
	output mosa_pkg::data_t        second_data
);
	import mosa_pkg::*;

	data_t first_mem [DEPTH];
	data_t second_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			first_mem[wr.addr]  <= wr.first_value;
			second_mem[wr.addr] <= wr.second_value;
		end
	end

	always_ff @(posedge clk) begin
		first_data  <= first_mem[rd.first_addr];
		second_data <= second_mem[rd.second_addr];
	end
endmodule
`default_nettype wire

FILE: tb/median_of_two_sorted_arrays_core_tb.sv
// Self-checking testbench for median_of_two_sorted_arrays_core: directed and random sets of
// pairs, mostly sorted, a local median predictor and a result scoreboard with random stalls
// on both sides. Depends on mosa_pkg, mosa_if and the core itself.
`default_nettype none
module median_of_two_sorted_arrays_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mosa_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_ITEMS = 450;
	localparam int TAIL_CYCLES  = 60;
	localparam int CYCLE_LIMIT  = 600000;

	localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam longint LONG_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;

	typedef enum int { SET_SORTED, SET_CLUSTERED, SET_SCRAMBLED } set_kind_t;

	typedef struct {
		data_t first_value;
		data_t second_value;
		logic  last_pair;
		bit    drain_first;
	} pair_item_t;

	logic clk;
	logic arst_n;

	mosa_pair_if   pairs_if();
	mosa_result_if result_if();

	median_of_two_sorted_arrays_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pairs  (pairs_if),
		.result (result_if)
	);

	pair_item_t  pending_pairs[$];
	data_t       median_expect[$];
	pair_item_t  next_pair;
	data_t       median_due;

	// Predictor copy of the two stores and the load position.
	data_t       first_mem [DEPTH];
	data_t       second_mem[DEPTH];
	int unsigned load_count;

	int unsigned pairs_queued;
	int unsigned pairs_taken;
	int unsigned cycle_count;
	int unsigned failures;
	int unsigned send_gap;
	int unsigned take_stall;
	bit          pair_accepted;
	bit          calm;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic data_t rand_data();
		return data_t'({$urandom, $urandom});
	endfunction

	// Mostly short gaps, now and then a long one; none at all while calm.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Halving search over the first n stored pairs.
	function automatic data_t search_median(int unsigned n);
		int unsigned flo, fhi, slo, shi, fm, sm;
		bit          odd_span;
		data_t       fv, sv;
		flo = 0;
		fhi = n - 1;
		slo = 0;
		shi = n - 1;
		while (flo != fhi && slo != shi) begin
			fm = (flo + fhi) / 2;
			sm = (slo + shi) / 2;
			odd_span = ((flo + fhi) % 2) == 0;
			fv = first_mem[fm];
			sv = second_mem[sm];
			if (fv == sv)
				return fv;
			if (sv < fv) begin
				fhi = fm;
				slo = odd_span ? sm : sm + 1;
			end else begin
				shi = sm;
				flo = odd_span ? fm : fm + 1;
			end
		end
		fv = first_mem[flo];
		sv = second_mem[slo];
		return (fv < sv) ? fv : sv;
	endfunction

	task automatic store_pair(data_t a, data_t b, logic last);
		if (load_count < DEPTH) begin
			first_mem[load_count]  = a;
			second_mem[load_count] = b;
			load_count++;
		end
		if (last) begin
			median_expect.push_back(search_median(load_count));
			load_count = 0;
		end
	endtask

	task automatic queue_pair(data_t a, data_t b, logic last, bit drain);
		pair_item_t item;
		item.first_value  = a;
		item.second_value = b;
		item.last_pair    = last;
		item.drain_first  = drain;
		pending_pairs.push_back(item);
		pairs_queued++;
	endtask

	task automatic ascending(ref data_t seq[$], input int n, input set_kind_t kind);
		longint      v;
		int unsigned step_max;
		seq.delete();
		if (kind == SET_CLUSTERED) begin
			// Narrow value range, so that midpoints often meet on equal values.
			v = longint'($urandom_range(0, 4)) - 2;
			step_max = 1;
		end else begin
			v = longint'(rand_data());
			case ($urandom_range(0, 3))
				0: step_max = 3;
				1: step_max = 255;
				2: step_max = 65535;
				default: step_max = 1 << 28;
			endcase
		end
		for (int i = 0; i < n; i++) begin
			if (kind == SET_SCRAMBLED) begin
				seq.push_back(rand_data());
			end else begin
				seq.push_back(data_t'(v));
				v = v + longint'($urandom_range(0, step_max));
				if (v > LONG_MAX)
					v = LONG_MAX;
			end
		end
	endtask

	task automatic make_set(int n, set_kind_t kind, bit drain);
		data_t fa[$];
		data_t sa[$];
		ascending(fa, n, kind);
		ascending(sa, n, kind);
		for (int i = 0; i < n; i++)
			queue_pair(fa[i], sa[i], i == n - 1, drain && i == 0);
	endtask

	task automatic directed_sets();
		// Single pairs at the extremes, both orders, and an equal pair.
		queue_pair(DATA_MIN, DATA_MAX, 1'b1, 1'b0);
		queue_pair(DATA_MAX, DATA_MIN, 1'b1, 1'b0);
		queue_pair(DATA_MAX, DATA_MAX, 1'b1, 1'b0);
		// Equal midpoints on the first step.
		queue_pair(DATA_MIN, DATA_MIN, 1'b0, 1'b0);
		queue_pair(DATA_MAX, DATA_MAX, 1'b1, 1'b0);
		queue_pair(-32'sd5, -32'sd7, 1'b0, 1'b0);
		queue_pair(32'sd3, 32'sd3, 1'b0, 1'b0);
		queue_pair(32'sd9, 32'sd11, 1'b1, 1'b0);
		// First sequence entirely below the second.
		queue_pair(DATA_MIN, 32'sd100, 1'b0, 1'b0);
		queue_pair(-32'sd1, 32'sd200, 1'b0, 1'b0);
		queue_pair(32'sd0, 32'sd300, 1'b0, 1'b0);
		queue_pair(32'sd1, DATA_MAX, 1'b1, 1'b0);
		// Unsorted input still runs the same steps.
		queue_pair(32'sd50, -32'sd3, 1'b0, 1'b0);
		queue_pair(-32'sd20, 32'sd70, 1'b0, 1'b0);
		queue_pair(DATA_MAX, DATA_MIN, 1'b0, 1'b0);
		queue_pair(32'sd4, 32'sd4, 1'b0, 1'b0);
		queue_pair(DATA_MIN, 32'sd8, 1'b1, 1'b0);
		// Second sequence entirely below the first.
		queue_pair(32'sd10, -32'sd10, 1'b0, 1'b0);
		queue_pair(32'sd20, -32'sd9, 1'b1, 1'b0);
	endtask

	task automatic random_sets();
		int          n, r, count;
		set_kind_t   kind;
		count = 0;
		while (count < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				n = $urandom_range(1, 8);
			else if (r < 95)
				n = $urandom_range(9, 40);
			else
				n = $urandom_range(41, 100);
			r = $urandom_range(0, 99);
			kind = (r < 70) ? SET_SORTED : (r < 85) ? SET_CLUSTERED : SET_SCRAMBLED;
			make_set(n, kind, count == 0 || $urandom_range(0, 19) == 0);
			count += n;
		end
	endtask

	// Input driver and result-side stalls; everything changes on the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 299) == 0)
				calm = !calm;
			if (!pairs_if.valid || pair_accepted) begin
				pair_accepted = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
					pairs_if.valid <= 1'b0;
				end else if (pending_pairs.size() == 0) begin
					pairs_if.valid <= 1'b0;
				end else if (pending_pairs[0].drain_first && median_expect.size() != 0) begin
					pairs_if.valid <= 1'b0;
				end else begin
					next_pair = pending_pairs.pop_front();
					pairs_if.first_value  <= next_pair.first_value;
					pairs_if.second_value <= next_pair.second_value;
					pairs_if.last_pair    <= next_pair.last_pair;
					pairs_if.valid        <= 1'b1;
					send_gap = pick_gap();
				end
			end
			if (take_stall > 0) begin
				take_stall--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					take_stall = pick_gap();
			end
		end
	end

	// Monitor: a pair transaction feeds the predictor, a result transaction is checked.
	always @(posedge clk) begin
		cycle_count++;
		if (arst_n) begin
			if (pairs_if.valid && pairs_if.ready) begin
				store_pair(pairs_if.first_value, pairs_if.second_value, pairs_if.last_pair);
				pairs_taken++;
				pair_accepted = 1'b1;
			end
			if (result_if.valid && result_if.ready) begin
				if (median_expect.size() == 0) begin
					$error("median_value: expected none, actual %0d", result_if.median_value);
					failures++;
				end else begin
					median_due = median_expect.pop_front();
					if (result_if.median_value !== median_due) begin
						$error("median_value: expected %0d, actual %0d", median_due,
							result_if.median_value);
						failures++;
					end
				end
			end
		end
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("median_of_two_sorted_arrays_core: mismatch");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		pairs_if.valid = 1'b0;
		pairs_if.first_value = '0;
		pairs_if.second_value = '0;
		pairs_if.last_pair = 1'b0;
		result_if.ready = 1'b0;
		load_count = 0;
		pairs_queued = 0;
		pairs_taken = 0;
		cycle_count = 0;
		failures = 0;
		send_gap = 0;
		take_stall = 0;
		pair_accepted = 1'b0;
		calm = 1'b0;

		directed_sets();
		random_sets();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pairs_taken != pairs_queued)
			@(posedge clk);
		while (median_expect.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("median_of_two_sorted_arrays_core: match");
		else
			$display("median_of_two_sorted_arrays_core: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
design/mosa_pkg.sv
design/mosa_if.sv
design/mosa_store.sv
design/median_of_two_sorted_arrays_core.sv
tb/median_of_two_sorted_arrays_core_tb.sv
